### rtl/cbnc_pkg.sv
package cbnc_pkg;

    // Coverage map geometry
    localparam int MAP_BYTES = 65536;
    localparam int MAP_AW    = $clog2(MAP_BYTES);

    // Field widths
    localparam int POS_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 17;

    // Result queue depth behind the compute stage
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef logic [MAP_AW-1:0]  addr_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_BUCKET_CMP  = 2'd0,
        OP_CMP_RAW     = 2'd1,
        OP_MERGE       = 2'd2,
        OP_BUCKET_ONLY = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] position;
        byte_t            hit_value;
        logic             last;
    } req_t;

    typedef struct packed {
        byte_t  classified_value;
        logic   new_byte_hit;
        logic   new_bit_hit;
        count_t new_byte_total;
        count_t new_bit_total;
        logic   pass_done;
    } rsp_t;

    // Hit-count classes 0,1,2,4,8,16,32,64,128
    function automatic byte_t bucket_of(input byte_t v);
        byte_t b;
        priority if (v <= 8'd2)
            b = v;
        else if (v == 8'd3)
            b = 8'd4;
        else if (v < 8'd8)
            b = 8'd8;
        else if (v < 8'd16)
            b = 8'd16;
        else if (v < 8'd32)
            b = 8'd32;
        else if (v < 8'd128)
            b = 8'd64;
        else
            b = 8'd128;
        return b;
    endfunction

endpackage

### rtl/cbnc_if.sv
interface cbnc_req_if;
    logic              valid;
    logic              ready;
    cbnc_pkg::req_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbnc_rsp_if;
    logic              valid;
    logic              ready;
    cbnc_pkg::rsp_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/cbnc_ram.sv
module cbnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port (read returns old data)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/coverage_bitmap_novelty_check_unit.sv
// Channel   Dir  Payload                                             Handshake
// trace     in   op, position, hit_value, last                       valid/ready
// result    out  classified_value, new_byte_hit, new_bit_hit,        valid/ready
//                new_byte_total, new_bit_total, pass_done
//
// One request per cycle sustained while the result side keeps up; each accepted request
// registers in the accept stage (map read issued), then passes the compute/writeback stage.
// After reset, a clearing pass writes zero to all MAP_BYTES map entries, one per
// cycle; trace.ready stays low until it completes.
// A three-entry result queue absorbs output stalls; after the clearing pass, trace.ready
// drops only when the queue plus the in-flight request would overflow it.
// A merge followed directly by a read of the same entry is served by forwarding.
module coverage_bitmap_novelty_check_unit (
    input  logic         clk,
    input  logic         rst_n,
    cbnc_req_if.sink     trace,
    cbnc_rsp_if.source   result
);

    // ---------------------------------------------------------------
    // Clearing pass after reset
    // ---------------------------------------------------------------
    logic              clr_active_reg;
    cbnc_pkg::addr_t   clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == cbnc_pkg::addr_t'(cbnc_pkg::MAP_BYTES - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Accept stage: issue the map read
    // ---------------------------------------------------------------
    logic                         accept;
    logic                         s1_valid_reg;
    cbnc_pkg::req_t               s1_req_reg;
    logic                         s1_in_map_reg;
    cbnc_pkg::addr_t              s1_addr_reg;
    logic [cbnc_pkg::OUTQ_CW-1:0] q_cnt_reg;
    cbnc_pkg::addr_t              rd_addr;
    logic                         in_map;

    // Room for the in-flight request plus the queued results
    assign trace.ready = !clr_active_reg
                      && ((cbnc_pkg::OUTQ_CW + 1)'(q_cnt_reg)
                          + (cbnc_pkg::OUTQ_CW + 1)'(s1_valid_reg)
                          < (cbnc_pkg::OUTQ_CW + 1)'(cbnc_pkg::OUTQ_DEPTH));
    assign accept  = trace.valid && trace.ready;
    assign rd_addr = cbnc_pkg::addr_t'(trace.data.position);
    assign in_map  = 32'(trace.data.position) < 32'(cbnc_pkg::MAP_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg    <= trace.data;
            s1_in_map_reg <= in_map;
            s1_addr_reg   <= rd_addr;
        end
    end

    // ---------------------------------------------------------------
    // Map memory
    // ---------------------------------------------------------------
    logic              map_we;
    cbnc_pkg::addr_t   map_waddr;
    cbnc_pkg::byte_t   map_wdata;
    cbnc_pkg::byte_t   map_rdata;

    cbnc_ram #(
        .WIDTH (cbnc_pkg::BYTE_W),
        .DEPTH (cbnc_pkg::MAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (rd_addr),
        .rdata (map_rdata)
    );

    // ---------------------------------------------------------------
    // Compute / writeback stage
    // ---------------------------------------------------------------
    logic              fwd_valid_reg;
    cbnc_pkg::addr_t   fwd_addr_reg;
    cbnc_pkg::byte_t   fwd_data_reg;
    cbnc_pkg::count_t  byte_cnt_reg;
    cbnc_pkg::count_t  bit_cnt_reg;
    cbnc_pkg::count_t  byte_cnt_next;
    cbnc_pkg::count_t  bit_cnt_next;
    cbnc_pkg::count_t  byte_total;
    cbnc_pkg::count_t  bit_total;
    cbnc_pkg::byte_t   entry;
    cbnc_pkg::byte_t   value;
    logic              do_cmp;
    logic              item_we;
    logic              novel;
    logic              byte_new;
    logic              bit_new;
    cbnc_pkg::rsp_t    s1_rsp;

    always_comb
    begin
        // Entry: zero outside the map, forwarded from a merge of the previous cycle, else RAM data
        if (!s1_in_map_reg)
            entry = '0;
        else if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
            entry = fwd_data_reg;
        else
            entry = map_rdata;

        value   = s1_req_reg.hit_value;
        do_cmp  = 1'b0;
        item_we = 1'b0;
        unique case (s1_req_reg.op)
            cbnc_pkg::OP_MERGE:
            begin
                if (s1_in_map_reg)
                begin
                    value   = entry | s1_req_reg.hit_value;
                    item_we = s1_valid_reg;
                end
            end
            cbnc_pkg::OP_CMP_RAW:
            begin
                do_cmp = 1'b1;
            end
            cbnc_pkg::OP_BUCKET_CMP:
            begin
                value  = cbnc_pkg::bucket_of(s1_req_reg.hit_value);
                do_cmp = 1'b1;
            end
            cbnc_pkg::OP_BUCKET_ONLY:
            begin
                value = cbnc_pkg::bucket_of(s1_req_reg.hit_value);
            end
            default:
            begin
                value = s1_req_reg.hit_value;
            end
        endcase

        novel    = do_cmp && s1_in_map_reg && ((value | entry) != entry);
        byte_new = novel && (entry == '0);
        bit_new  = novel && (entry != '0);

        // Saturating running counts, this request included
        byte_total = byte_cnt_reg;
        if (byte_new && (byte_cnt_reg != cbnc_pkg::COUNT_MAX))
            byte_total = byte_cnt_reg + 1'b1;
        bit_total = bit_cnt_reg;
        if (bit_new && (bit_cnt_reg != cbnc_pkg::COUNT_MAX))
            bit_total = bit_cnt_reg + 1'b1;

        byte_cnt_next = byte_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        if (s1_valid_reg)
        begin
            byte_cnt_next = s1_req_reg.last ? '0 : byte_total;
            bit_cnt_next  = s1_req_reg.last ? '0 : bit_total;
        end

        s1_rsp.classified_value = value;
        s1_rsp.new_byte_hit     = byte_new;
        s1_rsp.new_bit_hit      = bit_new;
        s1_rsp.new_byte_total   = byte_total;
        s1_rsp.new_bit_total    = bit_total;
        s1_rsp.pass_done        = s1_req_reg.last;
    end

    // Write port: clearing pass or merge writeback
    always_comb
    begin
        if (clr_active_reg)
        begin
            map_we    = 1'b1;
            map_waddr = clr_addr_reg;
            map_wdata = '0;
        end
        else
        begin
            map_we    = item_we;
            map_waddr = s1_addr_reg;
            map_wdata = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            byte_cnt_reg  <= '0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            fwd_valid_reg <= item_we;
            byte_cnt_reg  <= byte_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= value;
        end
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    cbnc_pkg::rsp_t               q_mem_reg [cbnc_pkg::OUTQ_DEPTH];
    logic [cbnc_pkg::OUTQ_PW-1:0] q_wr_reg;
    logic [cbnc_pkg::OUTQ_PW-1:0] q_rd_reg;
    logic                         q_push;
    logic                         q_pop;

    assign q_push       = s1_valid_reg;
    assign q_pop        = result.valid && result.ready;
    assign result.valid = (q_cnt_reg != '0);
    assign result.data  = q_mem_reg[q_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
            begin
                q_wr_reg <= (q_wr_reg == cbnc_pkg::OUTQ_PW'(cbnc_pkg::OUTQ_DEPTH - 1))
                          ? '0 : q_wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                q_rd_reg <= (q_rd_reg == cbnc_pkg::OUTQ_PW'(cbnc_pkg::OUTQ_DEPTH - 1))
                          ? '0 : q_rd_reg + 1'b1;
            end
            if (q_push && !q_pop)
                q_cnt_reg <= q_cnt_reg + 1'b1;
            else if (q_pop && !q_push)
                q_cnt_reg <= q_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem_reg[q_wr_reg] <= s1_rsp;
        end
    end

endmodule

### rtl/cbnc_checker.sv
module cbnc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input cbnc_pkg::rsp_t out_data
);

    // A hit is either on a zero entry or a nonzero one, never both
    a_hit_kinds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.new_byte_hit && out_data.new_bit_hit))
        else $error("new_byte_hit and new_bit_hit both set");

    // Totals include the current hit
    a_byte_total_counts_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.new_byte_hit) |-> (out_data.new_byte_total != '0))
        else $error("new_byte_total zero on a new-byte hit");

    a_bit_total_counts_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.new_bit_hit) |-> (out_data.new_bit_total != '0))
        else $error("new_bit_total zero on a new-bit hit");

    // Map clearing blocks requests right after reset
    a_ready_low_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("request accepted before map clearing");

    // Stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule

bind coverage_bitmap_novelty_check_unit cbnc_checker u_cbnc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (trace.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

### tb/sv/tb_coverage_bitmap_novelty_check_unit.sv
module tb_coverage_bitmap_novelty_check_unit;
    import cbnc_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int LONG_HOLD      = 80;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int DRAIN_LIMIT    = 20_000;
    localparam int DRAIN_TAIL     = 8;
    localparam int HIT_PAIRS      = 8;
    localparam int POOL_SIZE      = 16;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_MOSTLY
    } rx_mode_t;

    // Predicts novelty results and holds them until the block answers
    class novelty_scoreboard;
        byte_t  cov_map [MAP_BYTES];
        count_t byte_hits;
        count_t bit_hits;
        rsp_t   expected_q [$];
        int     failures;
        int     checked;
        int     byte_hit_total;
        int     bit_hit_total;
        int     passes_closed;
        bit     byte_sat_seen;
        bit     bit_sat_seen;

        function new();
            foreach (cov_map[i])
                cov_map[i] = '0;
            byte_hits      = '0;
            bit_hits       = '0;
            failures       = 0;
            checked        = 0;
            byte_hit_total = 0;
            bit_hit_total  = 0;
            passes_closed  = 0;
            byte_sat_seen  = 1'b0;
            bit_sat_seen   = 1'b0;
        endfunction

        // Hit-count class, worked from the top bit down
        function byte_t hit_class(byte_t v);
            if (v[7])
                return 8'd128;
            else if (v >= 8'd32)
                return 8'd64;
            else if (v >= 8'd16)
                return 8'd32;
            else if (v >= 8'd8)
                return 8'd16;
            else if (v >= 8'd4)
                return 8'd8;
            else if (v == 8'd3)
                return 8'd4;
            return v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void log_failure(string msg);
            if (failures < 10)
                $display("[%0t] %s", $time, msg);
            failures++;
        endfunction

        function void note_request(req_t r);
            bit    in_map;
            byte_t entry;
            rsp_t  e;
            in_map = int'(r.position) < MAP_BYTES;
            entry  = in_map ? cov_map[r.position] : '0;
            e      = '0;
            if (r.op == OP_MERGE)
            begin
                e.classified_value = in_map ? (entry | r.hit_value) : r.hit_value;
                if (in_map)
                    cov_map[r.position] = e.classified_value;
            end
            else
            begin
                e.classified_value = (r.op == OP_CMP_RAW) ? r.hit_value
                                                          : hit_class(r.hit_value);
                if (r.op != OP_BUCKET_ONLY && in_map
                    && ((e.classified_value | entry) != entry))
                begin
                    e.new_byte_hit = (entry == '0);
                    e.new_bit_hit  = (entry != '0);
                end
            end
            // saturating pass counters
            if (e.new_byte_hit)
            begin
                if (byte_hits != COUNT_MAX)
                    byte_hits = byte_hits + 1'b1;
                byte_hit_total++;
            end
            if (e.new_bit_hit)
            begin
                if (bit_hits != COUNT_MAX)
                    bit_hits = bit_hits + 1'b1;
                bit_hit_total++;
            end
            if (byte_hits == COUNT_MAX)
                byte_sat_seen = 1'b1;
            if (bit_hits == COUNT_MAX)
                bit_sat_seen = 1'b1;
            e.new_byte_total = byte_hits;
            e.new_bit_total  = bit_hits;
            e.pass_done      = r.last;
            if (r.last)
            begin
                byte_hits = '0;
                bit_hits  = '0;
                passes_closed++;
            end
            expected_q.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                log_failure($sformatf("unexpected result %h", got));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.classified_value !== e.classified_value
                || got.new_byte_hit !== e.new_byte_hit
                || got.new_bit_hit !== e.new_bit_hit
                || got.new_byte_total !== e.new_byte_total
                || got.new_bit_total !== e.new_bit_total
                || got.pass_done !== e.pass_done)
                log_failure($sformatf({"result %0d exp/act: value %h/%h byte_hit %b/%b",
                    " bit_hit %b/%b byte_total %0d/%0d bit_total %0d/%0d done %b/%b"},
                    checked, e.classified_value, got.classified_value,
                    e.new_byte_hit, got.new_byte_hit, e.new_bit_hit, got.new_bit_hit,
                    e.new_byte_total, got.new_byte_total,
                    e.new_bit_total, got.new_bit_total, e.pass_done, got.pass_done));
        endfunction

        function void finish_check();
            if (expected_q.size() != 0)
                log_failure($sformatf("%0d results never arrived", expected_q.size()));
            failures += (expected_q.size() > 1) ? expected_q.size() - 1 : 0;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    cbnc_req_if  trace_ch ();
    cbnc_rsp_if  result_ch ();

    novelty_scoreboard sb = new();

    rx_mode_t    rx_mode;
    int          rx_tick;
    int          hold_left;
    int          holds_asked;
    int          holds_done;
    int          burst_left;
    int          max_gap;
    int unsigned pos_pool [POOL_SIZE];

    coverage_bitmap_novelty_check_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .trace  (trace_ch),
        .result (result_ch)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("** coverage_bitmap_novelty_check_unit: FAILED **");
        $finish;
    end

    // Watch both channels; values sampled here are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (trace_ch.valid && trace_ch.ready)
                sb.note_request(trace_ch.data);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.data);
        end
    end

    // Result side: long hold when asked, otherwise the current stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_tick <= rx_tick + 1;
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left       <= hold_left - 1;
            end
            else if (holds_asked != holds_done)
            begin
                result_ch.ready <= 1'b0;
                hold_left       <= LONG_HOLD - 1;
                holds_done      <= holds_done + 1;
            end
            else
            begin
                case (rx_mode)
                    RX_RANDOM:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: result_ch.ready <= (rx_tick % 7) >= 3;
                    RX_MOSTLY:   result_ch.ready <= ($urandom_range(0, 9) != 0);
                    default:     result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    function automatic req_t mk_req(op_t op, int unsigned pos, int unsigned hit, bit last);
        req_t r;
        r.op        = op;
        r.position  = pos[POS_W-1:0];
        r.hit_value = hit[BYTE_W-1:0];
        r.last      = last;
        return r;
    endfunction

    // Random request: positions mostly from a small pool so merges and compares meet
    function automatic req_t random_trace(bit last);
        req_t        r;
        int unsigned k;
        k = $urandom_range(0, 99);
        r.op = (k < 30) ? OP_BUCKET_CMP : (k < 55) ? OP_CMP_RAW
             : (k < 85) ? OP_MERGE : OP_BUCKET_ONLY;
        if ($urandom_range(0, 99) < 65)
            r.position = POS_W'(pos_pool[$urandom_range(0, POOL_SIZE - 1)]);
        else
            r.position = POS_W'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 4))
            0:       r.hit_value = BYTE_W'($urandom_range(0, 9));
            1:       r.hit_value = BYTE_W'($urandom_range(0, 40));
            2:       r.hit_value = BYTE_W'(8'h01 << $urandom_range(0, 7));
            default: r.hit_value = BYTE_W'($urandom_range(0, 255));
        endcase
        r.last = last;
        return r;
    endfunction

    // Hold the request until the block takes it
    task automatic offer(input req_t r);
        trace_ch.valid <= 1'b1;
        trace_ch.data  <= r;
        do
            @(posedge clk);
        while (!trace_ch.ready);
    endtask

    // Bursts of random length separated by random gaps
    task automatic send_item(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0)
            begin
                trace_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        offer(r);
        burst_left--;
    endtask

    task automatic wait_drained();
        trace_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        burst_left = 0;
    endtask

    // Whole passes of random length, each closed by a last request
    task automatic run_passes(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
                send_item(random_trace(i == len - 1));
            sent += len;
        end
    endtask

    initial
    begin
        req_t directed [$];
        int   sat_byte_pos;
        int   sat_bit_pos;
        int   waited;

        rst_n           = 1'b0;
        trace_ch.valid  = 1'b0;
        trace_ch.data   = '0;
        result_ch.ready = 1'b0;
        rx_mode         = RX_ALWAYS;
        rx_tick         = 0;
        hold_left       = 0;
        holds_asked     = 0;
        holds_done      = 0;
        burst_left      = 0;
        max_gap         = 0;
        pos_pool[0] = 0;
        pos_pool[1] = 16'hFFFF;
        pos_pool[2] = 1;
        pos_pool[3] = 16'h8000;
        for (int i = 4; i < POOL_SIZE; i++)
            pos_pool[i] = $urandom_range(0, 16'hFFFF);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Bucket table edges
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0100, 0, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0101, 1, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0102, 2, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0103, 3, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0104, 4, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0105, 7, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0106, 8, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0107, 15, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0108, 16, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h0109, 31, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h010A, 32, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h010B, 127, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h010C, 128, 0));
        directed.push_back(mk_req(OP_BUCKET_ONLY, 16'h010D, 255, 0));
        // zero byte against a zero entry, then first and extra bits at the top entry
        directed.push_back(mk_req(OP_CMP_RAW, 16'h0000, 8'h00, 0));
        directed.push_back(mk_req(OP_CMP_RAW, 16'hFFFF, 8'h80, 0));
        directed.push_back(mk_req(OP_MERGE, 16'hFFFF, 8'h80, 0));
        directed.push_back(mk_req(OP_CMP_RAW, 16'hFFFF, 8'h81, 0));
        directed.push_back(mk_req(OP_CMP_RAW, 16'hFFFF, 8'h80, 0));
        directed.push_back(mk_req(OP_BUCKET_CMP, 16'hFFFF, 200, 0));
        directed.push_back(mk_req(OP_BUCKET_CMP, 16'hFFFF, 3, 0));
        // full entry, pass end, then counters restart
        directed.push_back(mk_req(OP_MERGE, 16'h0000, 8'hFF, 0));
        directed.push_back(mk_req(OP_BUCKET_CMP, 16'h0000, 255, 1));
        directed.push_back(mk_req(OP_CMP_RAW, 16'h8000, 8'h7F, 0));
        foreach (directed[i])
            send_item(directed[i]);
        wait_drained();

        // Random passes under random output stalls and input gaps
        rx_mode <= RX_RANDOM;
        max_gap = 6;
        run_passes(170);

        // Output held off while requests keep coming
        holds_asked <= holds_asked + 1;
        max_gap = 0;
        burst_left = 0;
        run_passes(30);
        wait_drained();

        rx_mode <= RX_PERIODIC;
        run_passes(170);

        rx_mode <= RX_MOSTLY;
        max_gap = 10;
        run_passes(190);
        wait_drained();

        // Back-to-back hits on a zero entry and on a partial entry
        rx_mode <= RX_ALWAYS;
        max_gap = 0;
        sat_byte_pos = -1;
        sat_bit_pos  = -1;
        for (int p = 16'h1000; p < MAP_BYTES && sat_bit_pos < 0; p++)
        begin
            if (sb.cov_map[p] == '0)
            begin
                if (sat_byte_pos < 0)
                    sat_byte_pos = p;
                else
                    sat_bit_pos = p;
            end
        end
        offer(mk_req(OP_MERGE, sat_bit_pos, 8'h01, 0));
        for (int i = 0; i < HIT_PAIRS; i++)
        begin
            offer(mk_req(OP_CMP_RAW, sat_byte_pos, 8'h01, 0));
            offer(mk_req(OP_CMP_RAW, sat_bit_pos, 8'h02, 0));
        end
        offer(mk_req(OP_CMP_RAW, sat_byte_pos, 8'h10, 1));
        offer(mk_req(OP_CMP_RAW, sat_bit_pos, 8'h04, 0));
        trace_ch.valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_TAIL) @(posedge clk);
        sb.finish_check();

        $display("Run: %0d results checked over %0d passes, %0d new-byte and %0d new-bit hits",
                 sb.checked, sb.passes_closed, sb.byte_hit_total, sb.bit_hit_total);
        $display("     counters saturated (byte %b, bit %b), %0d long output hold(s), %0d failures",
                 sb.byte_sat_seen, sb.bit_sat_seen, holds_done, sb.failures);
        if (sb.failures == 0)
            $display("** coverage_bitmap_novelty_check_unit: PASSED **");
        else
            $display("** coverage_bitmap_novelty_check_unit: FAILED **");
        $finish;
    end

endmodule
